>>> design/sme_pkg.sv
// Package for the stack machine executor: operation codes, item types and helpers.
package sme_pkg;

	localparam int unsigned StackDepthDefault = 256;
	localparam int unsigned OpW   = 5;
	localparam int unsigned DataW = 64;
	localparam int unsigned KindW = 3;
	localparam int unsigned StatW = 3;
	localparam int unsigned JumpW = 32;
	localparam int unsigned DepW  = 9;

	typedef enum logic [OpW-1:0] {
		OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
		OP_MOD = 5'd5, OP_OUT = 5'd6, OP_PUT = 5'd7, OP_DUP = 5'd8, OP_DUP2 = 5'd9,
		OP_ROT = 5'd10, OP_SWAP = 5'd11, OP_DROP = 5'd12, OP_IF = 5'd13, OP_END = 5'd14,
		OP_GT = 5'd15, OP_GE = 5'd16, OP_EQ = 5'd17, OP_LE = 5'd18, OP_LT = 5'd19,
		OP_NE = 5'd20, OP_EOF = 5'd21
	} op_t;

	typedef enum logic [KindW-1:0] {
		KIND_NONE = 3'd0, KIND_NUM = 3'd1, KIND_CHAR = 3'd2, KIND_RET = 3'd3,
		KIND_JUMP = 3'd4
	} kind_t;

	typedef enum logic [StatW-1:0] {
		ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3, ST_INVAL = 3'd4
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_CAP, S_MUL0, S_MUL1, S_MUL2, S_DIV, S_EXEC,
		S_WR0, S_WR1, S_WR2, S_DONE
	} state_t;

	typedef struct packed {
		logic [OpW-1:0]   operation;
		logic [DataW-1:0] immediate;
	} in_item_t;

	typedef struct packed {
		logic [KindW-1:0] result_kind;
		logic [DataW-1:0] out_value;
		logic [JumpW-1:0] jump_target;
		logic [StatW-1:0] status;
		logic [DepW-1:0]  depth_after;
	} out_item_t;

	// Number of entries an operation reads.
	function automatic logic [1:0] need_of(input logic [OpW-1:0] op);
		case (op)
			OP_PUSH, OP_END: need_of = 2'd0;
			OP_OUT, OP_PUT, OP_DUP, OP_DROP, OP_IF, OP_EOF: need_of = 2'd1;
			OP_ROT: need_of = 2'd3;
			default: need_of = 2'd2;
		endcase
	endfunction

	// Net growth of the stack: encoded as 0 => -1, 1 => 0, 2 => +1, 3 => +2.
	function automatic logic [1:0] net_of(input logic [OpW-1:0] op);
		case (op)
			OP_PUSH, OP_DUP: net_of = 2'd2;
			OP_DUP2: net_of = 2'd3;
			OP_ROT, OP_SWAP, OP_END: net_of = 2'd1;
			default: net_of = 2'd0;
		endcase
	endfunction

endpackage

>>> design/sme_ram.sv
// Generic single-port synchronous RAM with a registered read.
module sme_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Read data is registered; a write to the same address returns the old entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> design/sme_div.sv
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
module sme_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [sme_pkg::DataW-1:0] dividend,
	input  logic [sme_pkg::DataW-1:0] divisor,
	output logic                    busy,
	output logic                    done,
	output logic [sme_pkg::DataW-1:0] quotient,
	output logic [sme_pkg::DataW-1:0] remainder
);

	localparam int unsigned W = sme_pkg::DataW;

	logic [$clog2(W)-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [W-1:0]         quo_q;
	logic [W-1:0]         rem_q;
	logic [W-1:0]         dvs_q;
	logic [W:0]           trial;
	logic [W:0]           shifted;

	// One restoring step: shift the next dividend bit in, try the subtract.
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(W)'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], ~trial[W]};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> design/stack_machine_executor_top.sv
// Top level of the stack machine executor: control, stack memory and divider.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | sme_pkg::in_item_t
//   out     | output    | out_valid/out_ready| sme_pkg::out_item_t
//
// One item at a time: operands are read one per cycle, then results are written one per
// cycle. Push and end skip the reads, mul adds multiply steps, div or mod by nonzero waits
// for the divider, and div by zero goes from capture straight to done. Invalid, underflow
// and overflow items are answered from idle, without reading or writing the stack.
// Reset empties the stack at once; stack entries are not cleared.
// The result waits in an output register; while it is not taken no new item enters.
module stack_machine_executor_top #(
	parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sme_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output sme_pkg::out_item_t out_item
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned W  = sme_pkg::DataW;
	localparam int unsigned HW = W / 2;

	sme_pkg::state_t state_q, state_d;

	logic [PW-1:0]              sp_q;
	logic [sme_pkg::OpW-1:0]    op_q;
	logic [W-1:0]               imm_q;
	logic [W-1:0]               a_q, b_q, c_q, r_q;
	logic [W-1:0]               prod_q;
	logic [1:0]                 need_q;
	logic [PW-1:0]              base_q;
	logic                       out_valid_q;
	sme_pkg::out_item_t         out_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic [W-1:0]               ram_wdata;
	logic [W-1:0]               ram_rdata;
	logic                       div_start;
	logic                       div_busy;
	logic                       div_done;
	logic [W-1:0]               div_quo, div_rem;

	logic [1:0]                 need_in;
	logic [1:0]                 net_in;
	logic [PW:0]                grow_in;
	logic                       bad_in, under_in, over_in;
	logic                       accept;
	logic [W-1:0]               b_cur;
	logic [HW-1:0]              mul_x, mul_y;
	logic [W-1:0]               mul_p;
	logic [1:0]                 wr_cnt;
	logic [PW-1:0]              sp_new;
	logic [W-1:0]               wr_val [3];
	logic [1:0]                 wr_n;
	logic [sme_pkg::KindW-1:0]  kind;
	logic [W-1:0]               val;
	logic [sme_pkg::JumpW-1:0]  jmp;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == sme_pkg::S_IDLE) && !out_valid_q;

	// Checks of the incoming item against the pointer.
	always_comb begin
		need_in  = sme_pkg::need_of(in_item.operation);
		net_in   = sme_pkg::net_of(in_item.operation);
		bad_in   = in_item.operation > sme_pkg::OP_EOF;
		under_in = {{(PW-2){1'b0}}, need_in} > sp_q;
		grow_in  = {1'b0, sp_q} + {{(PW-1){1'b0}}, net_in} - (PW+1)'(1);
		over_in  = net_in[1] && (grow_in > (PW+1)'(STACK_DEPTH));
	end

	// For two-operand items the second operand arrives from the memory during the capture cycle.
	assign b_cur = (state_q == sme_pkg::S_CAP && need_q == 2'd2) ? ram_rdata : b_q;

	// Stack memory and divider.
	sme_ram #(.Width(W), .Depth(STACK_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	sme_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(a_q), .divisor(b_cur),
		.busy(div_busy), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	// Shared 32 by 32 multiplier: low halves first, then the two cross products.
	always_comb begin
		mul_x = a_q[HW-1:0];
		mul_y = b_q[HW-1:0];
		case (state_q)
			sme_pkg::S_MUL1: mul_y = b_q[W-1:HW];
			sme_pkg::S_MUL2: mul_x = a_q[W-1:HW];
			default: begin
				mul_x = a_q[HW-1:0];
			end
		endcase
		mul_p = W'(mul_x) * W'(mul_y);
	end

	// Entries written back, lowest address first, and their count.
	always_comb begin
		wr_val[0] = r_q;
		wr_val[1] = '0;
		wr_val[2] = '0;
		wr_n      = 2'd0;
		case (op_q)
			sme_pkg::OP_PUSH: begin
				wr_val[0] = imm_q;
				wr_n      = 2'd1;
			end
			sme_pkg::OP_DUP: begin
				wr_val[0] = a_q;
				wr_n      = 2'd1;
			end
			sme_pkg::OP_DUP2: begin
				wr_val[0] = a_q;
				wr_val[1] = b_q;
				wr_n      = 2'd2;
			end
			sme_pkg::OP_ROT: begin
				wr_val[0] = b_q;
				wr_val[1] = c_q;
				wr_val[2] = a_q;
				wr_n      = 2'd3;
			end
			sme_pkg::OP_SWAP: begin
				wr_val[0] = b_q;
				wr_val[1] = a_q;
				wr_n      = 2'd2;
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
			sme_pkg::OP_MOD, sme_pkg::OP_GT, sme_pkg::OP_GE, sme_pkg::OP_EQ,
			sme_pkg::OP_LE, sme_pkg::OP_LT, sme_pkg::OP_NE: begin
				wr_n = 2'd1;
			end
			default: begin
				wr_n = 2'd0;
			end
		endcase
	end

	// Stack pointer after the item, counted from the lowest entry read.
	always_comb begin
		case (op_q)
			sme_pkg::OP_DUP: sp_new = base_q + PW'(2);
			sme_pkg::OP_DUP2: sp_new = base_q + PW'(4);
			sme_pkg::OP_PUSH: sp_new = base_q + PW'(1);
			sme_pkg::OP_ROT: sp_new = base_q + PW'(3);
			sme_pkg::OP_SWAP: sp_new = base_q + PW'(2);
			sme_pkg::OP_END: sp_new = base_q;
			sme_pkg::OP_OUT, sme_pkg::OP_PUT, sme_pkg::OP_DROP, sme_pkg::OP_IF,
			sme_pkg::OP_EOF: sp_new = base_q;
			default: sp_new = base_q + PW'(1);
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sme_pkg::S_IDLE: begin
				if (accept && !bad_in && !under_in && !over_in) begin
					state_d = (need_in == 2'd0) ? sme_pkg::S_EXEC : sme_pkg::S_RD0;
				end
			end
			sme_pkg::S_RD0: state_d = (need_q == 2'd1) ? sme_pkg::S_CAP : sme_pkg::S_RD1;
			sme_pkg::S_RD1: state_d = (need_q == 2'd2) ? sme_pkg::S_CAP : sme_pkg::S_RD2;
			sme_pkg::S_RD2: state_d = sme_pkg::S_CAP;
			sme_pkg::S_CAP: begin
				if (op_q == sme_pkg::OP_DIV && b_cur == '0) begin
					state_d = sme_pkg::S_DONE;
				end else if ((op_q == sme_pkg::OP_DIV || op_q == sme_pkg::OP_MOD)
					&& b_cur != '0) begin
					state_d = sme_pkg::S_DIV;
				end else if (op_q == sme_pkg::OP_MUL) begin
					state_d = sme_pkg::S_MUL0;
				end else begin
					state_d = sme_pkg::S_EXEC;
				end
			end
			sme_pkg::S_MUL0: state_d = sme_pkg::S_MUL1;
			sme_pkg::S_MUL1: state_d = sme_pkg::S_MUL2;
			sme_pkg::S_MUL2: state_d = sme_pkg::S_EXEC;
			sme_pkg::S_DIV: state_d = div_done ? sme_pkg::S_EXEC : sme_pkg::S_DIV;
			sme_pkg::S_EXEC: state_d = (wr_n == 2'd0) ? sme_pkg::S_DONE : sme_pkg::S_WR0;
			sme_pkg::S_WR0: state_d = (wr_n == 2'd1) ? sme_pkg::S_DONE : sme_pkg::S_WR1;
			sme_pkg::S_WR1: state_d = (wr_n == 2'd2) ? sme_pkg::S_DONE : sme_pkg::S_WR2;
			sme_pkg::S_WR2: state_d = sme_pkg::S_DONE;
			sme_pkg::S_DONE: state_d = sme_pkg::S_IDLE;
			default: state_d = sme_pkg::S_IDLE;
		endcase
	end

	// Memory and divider controls per state.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = base_q[AW-1:0];
		ram_wdata = wr_val[0];
		wr_cnt    = 2'd0;
		div_start = 1'b0;
		case (state_q)
			sme_pkg::S_RD0: ram_addr = base_q[AW-1:0];
			sme_pkg::S_RD1: ram_addr = base_q[AW-1:0] + AW'(1);
			sme_pkg::S_RD2: ram_addr = base_q[AW-1:0] + AW'(2);
			sme_pkg::S_CAP: begin
				div_start = (op_q == sme_pkg::OP_DIV || op_q == sme_pkg::OP_MOD)
					&& b_cur != '0;
			end
			sme_pkg::S_WR0, sme_pkg::S_WR1, sme_pkg::S_WR2: begin
				wr_cnt = (state_q == sme_pkg::S_WR0) ? 2'd0 :
					(state_q == sme_pkg::S_WR1) ? 2'd1 : 2'd2;
				ram_we    = 1'b1;
				ram_wdata = wr_val[wr_cnt];
				ram_addr  = base_q[AW-1:0] + AW'(wr_cnt)
					+ ((op_q == sme_pkg::OP_DUP || op_q == sme_pkg::OP_DUP2) ?
					AW'(need_q) : AW'(0));
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Emitted fields.
	always_comb begin
		kind = sme_pkg::KIND_NONE;
		val  = '0;
		jmp  = '0;
		case (op_q)
			sme_pkg::OP_OUT: begin
				kind = sme_pkg::KIND_NUM;
				val  = a_q;
			end
			sme_pkg::OP_PUT: begin
				kind = sme_pkg::KIND_CHAR;
				val  = {{(W-8){1'b0}}, a_q[7:0]};
			end
			sme_pkg::OP_EOF: begin
				kind = sme_pkg::KIND_RET;
				val  = a_q;
			end
			sme_pkg::OP_IF: begin
				if (a_q == '0) begin
					kind = sme_pkg::KIND_JUMP;
					jmp  = imm_q[sme_pkg::JumpW-1:0] + sme_pkg::JumpW'(1);
				end
			end
			default: begin
				kind = sme_pkg::KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sme_pkg::S_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && (bad_in || under_in || over_in)) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == sme_pkg::S_DONE) begin
				out_valid_q <= 1'b1;
				if (!(op_q == sme_pkg::OP_DIV && b_q == '0)) begin
					sp_q <= sp_new;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_item.operation;
			imm_q  <= in_item.immediate;
			need_q <= need_in;
			base_q <= sp_q - PW'(need_in);
			out_q  <= '{result_kind: sme_pkg::KIND_NONE, out_value: '0, jump_target: '0,
				status: bad_in ? sme_pkg::ST_INVAL : under_in ? sme_pkg::ST_UNDER :
				sme_pkg::ST_OVER, depth_after: sme_pkg::DepW'(sp_q)};
		end
		case (state_q)
			sme_pkg::S_RD1: a_q <= ram_rdata;
			sme_pkg::S_RD2: b_q <= ram_rdata;
			sme_pkg::S_CAP: begin
				case (need_q)
					2'd1: a_q <= ram_rdata;
					2'd2: b_q <= ram_rdata;
					default: c_q <= ram_rdata;
				endcase
			end
			sme_pkg::S_MUL0: prod_q <= mul_p;
			sme_pkg::S_MUL1, sme_pkg::S_MUL2: begin
				prod_q <= prod_q + {mul_p[HW-1:0], {HW{1'b0}}};
			end
			sme_pkg::S_EXEC: begin
				case (op_q)
					sme_pkg::OP_ADD: r_q <= a_q + b_q;
					sme_pkg::OP_SUB: r_q <= a_q - b_q;
					sme_pkg::OP_MUL: r_q <= prod_q;
					sme_pkg::OP_DIV: r_q <= div_quo;
					sme_pkg::OP_MOD: r_q <= (b_q == '0) ? a_q : div_rem;
					sme_pkg::OP_GT: r_q <= W'(a_q > b_q);
					sme_pkg::OP_GE: r_q <= W'(a_q >= b_q);
					sme_pkg::OP_EQ: r_q <= W'(a_q == b_q);
					sme_pkg::OP_LE: r_q <= W'(a_q <= b_q);
					sme_pkg::OP_LT: r_q <= W'(a_q < b_q);
					sme_pkg::OP_NE: r_q <= W'(a_q != b_q);
					default: r_q <= r_q;
				endcase
			end
			sme_pkg::S_DONE: begin
				if (op_q == sme_pkg::OP_DIV && b_q == '0) begin
					out_q <= '{result_kind: sme_pkg::KIND_NONE, out_value: '0,
						jump_target: '0, status: sme_pkg::ST_DIVZ,
						depth_after: sme_pkg::DepW'(sp_q)};
				end else begin
					out_q <= '{result_kind: kind, out_value: val, jump_target: jmp,
						status: sme_pkg::ST_OK, depth_after: sme_pkg::DepW'(sp_new)};
				end
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	// The stack pointer never passes the depth.
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PW'(STACK_DEPTH)) else $error("stack pointer beyond depth");

	// No item enters while a result is pending or work is in flight.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == sme_pkg::S_IDLE && !out_valid_q))
		else $error("item accepted while busy");

	// The divider is only running while control waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == sme_pkg::S_DIV))
		else $error("divider running outside divide state");

	// The stack is written only in write-back states.
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == sme_pkg::S_WR0 || state_q == sme_pkg::S_WR1
		|| state_q == sme_pkg::S_WR2)) else $error("stack write outside write-back");
`endif

endmodule
